// File: rtl/assert_macros.svh
// Assertion macros shared by the scan driver RTL.
// Every macro uses clk and arst_n of the module that expands it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define LMSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmsd assertion failed");

// Next-cycle implication, muted while reset is asserted.
`define LMSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmsd assertion failed");

`endif

// File: rtl/lmsd_pkg.sv
// Types and constants for the LED matrix scan driver.
// No dependencies; used by the top level.
package lmsd_pkg;

	localparam int ROW_COLUMNS   = 256;
	localparam int SCAN_SECTIONS = 16;
	localparam int STORE_BYTES   = 1024;

	localparam int SEC_W    = $clog2(SCAN_SECTIONS);
	localparam int COL_W    = $clog2(ROW_COLUMNS);
	localparam int ADDR_W   = $clog2(STORE_BYTES);
	// Frame store is split on address bit 8: upper-half pixels never have it set,
	// lower-half pixels always do, so each tick reads one word from each bank.
	localparam int BANK_DEPTH  = STORE_BYTES / 2;
	localparam int BANK_ADDR_W = $clog2(BANK_DEPTH);
	localparam int BANK_SEL_BIT = 8;

	localparam logic [COL_W-1:0] LAST_COLUMN  = COL_W'(ROW_COLUMNS - 1);
	localparam logic [SEC_W-1:0] LAST_SECTION = SEC_W'(SCAN_SECTIONS - 1);
	localparam logic [BANK_ADDR_W-1:0] LAST_BANK_ADDR = BANK_ADDR_W'(BANK_DEPTH - 1);

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_TICK  = 1'b1
	} req_type_t;

	typedef logic [7:0] pix_byte_t;

endpackage

// File: rtl/lmsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lmsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/led_matrix_scan_driver_unit.sv
// Top level of the LED matrix scan driver.
// Depends on lmsd_pkg, lmsd_ram and assert_macros.svh.
`include "assert_macros.svh"

// Scans a 1024-byte, one-bit-per-pixel frame store onto a chained HUB75 row
// of 256 columns in 16 scan sections. An input word with tuser = write stores
// one frame byte and gives no result; a word with tuser = tick shifts one
// column and gives one result word: row select, column, upper and lower pixel
// and tlast on the last column, after which the section advances (wraps at 16).
// Rate: one word per cycle while m_tready stays high and no clearing pass runs.
// A tick's frame bank read is registered at the edge that takes it; the result
// word then moves from that bank read stage into the output register, which
// offers it. s_tready is low during the clearing pass and otherwise drops only
// while both the bank read stage and the output register hold a word and
// m_tready is low. A write is visible to a tick taken in the very next cycle.
// After reset a clearing pass zeroes every bank address (both banks in parallel).
module led_matrix_scan_driver_unit (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [9:0] byte_address, [17:10] byte_value, rest zero
	input  logic        s_tuser,   // [0] req_type (0 write, 1 tick)
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [3:0] row_select, [11:4] column_index,
	                               // [12] upper_on, [13] lower_on, rest zero
	output logic        m_tlast    // latch_row
);
	import lmsd_pkg::*;

	// input decode
	logic [ADDR_W-1:0]      byte_address;
	pix_byte_t              byte_value;
	logic                   in_acc, tick_acc, wr_acc;

	// scan position
	logic [SEC_W-1:0]       section_q;
	logic [COL_W-1:0]       column_q;
	logic [BANK_ADDR_W-1:0] rd_index;

	// clearing pass
	logic                   clearing_q;
	logic [BANK_ADDR_W-1:0] clr_addr_q;

	// bank write port
	logic                   we_up, we_lo;
	logic [BANK_ADDR_W-1:0] waddr;
	pix_byte_t              wdata;
	pix_byte_t              up_byte, lo_byte;

	// stage 1: bank read data
	logic                   valid_s1;
	logic [SEC_W-1:0]       section_s1;
	logic [COL_W-1:0]       column_s1;
	logic                   last_s1;
	logic                   move_s1;

	// output register
	logic                   out_valid_q;
	logic [SEC_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic                   upper_q, lower_q, last_q;

	assign byte_address = s_tdata[ADDR_W-1:0];
	assign byte_value   = s_tdata[ADDR_W +: 8];

	// s1 drains when the output register is free or being taken
	assign move_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !clearing_q && (!valid_s1 || !out_valid_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;
	assign tick_acc = in_acc && (s_tuser == REQ_TICK);
	assign wr_acc   = in_acc && (s_tuser == REQ_WRITE);

	// Both pixel addresses share {column[7], section[3], column[6:0]} once
	// address bit 8 (the bank select) is dropped.
	assign rd_index = {column_q[COL_W-1], section_q[SEC_W-1], column_q[COL_W-2:0]};

	// write port: clearing pass hits both banks, otherwise bit 8 picks one
	always_comb begin
		if (clearing_q) begin
			we_up = 1'b1;
			we_lo = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we_up = wr_acc && !byte_address[BANK_SEL_BIT];
			we_lo = wr_acc &&  byte_address[BANK_SEL_BIT];
			waddr = {byte_address[ADDR_W-1], byte_address[BANK_SEL_BIT-1:0]};
			wdata = byte_value;
		end
	end

	lmsd_ram #(
		.WIDTH (8),
		.DEPTH (BANK_DEPTH)
	) u_bank_up (
		.clk   (clk),
		.we    (we_up),
		.waddr (waddr),
		.wdata (wdata),
		.re    (tick_acc),
		.raddr (rd_index),
		.rdata (up_byte)
	);

	lmsd_ram #(
		.WIDTH (8),
		.DEPTH (BANK_DEPTH)
	) u_bank_lo (
		.clk   (clk),
		.we    (we_lo),
		.waddr (waddr),
		.wdata (wdata),
		.re    (tick_acc),
		.raddr (rd_index),
		.rdata (lo_byte)
	);

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_BANK_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// scan position advances on every tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_q <= '0;
			column_q  <= '0;
		end else if (tick_acc) begin
			if (column_q == LAST_COLUMN) begin
				column_q  <= '0;
				section_q <= (section_q == LAST_SECTION) ? '0 : section_q + 1'b1;
			end else begin
				column_q <= column_q + 1'b1;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_acc) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			section_s1 <= section_q;
			column_s1  <= column_q;
			last_s1    <= (column_q == LAST_COLUMN);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// pixel is bit (section mod 8) of each bank word
	always_ff @(posedge clk) begin
		if (move_s1) begin
			row_q   <= section_s1;
			col_q   <= column_s1;
			upper_q <= up_byte[section_s1[2:0]];
			lower_q <= lo_byte[section_s1[2:0]];
			last_q  <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, lower_q, upper_q, col_q, row_q};
	assign m_tlast  = last_q;

	`LMSD_ASSERT_IMP(a_no_accept_while_clearing, clearing_q, !s_tready)
	`LMSD_ASSERT_IMP(a_last_on_final_column, m_tvalid,
		m_tlast == (m_tdata[11:4] == LAST_COLUMN))
	`LMSD_ASSERT_NXT(a_tick_fills_s1, tick_acc, valid_s1)
	`LMSD_ASSERT_NXT(a_write_keeps_scan, wr_acc,
		$stable(column_q) && $stable(section_q))

endmodule

// File: tb/sv/led_matrix_scan_driver_unit_tb.sv
// Self-checking testbench for led_matrix_scan_driver_unit: frame writes and scan ticks.
// Depends on lmsd_pkg and the RTL of the block; a scoreboard class predicts each scan word.
`timescale 1ns / 100ps

module led_matrix_scan_driver_unit_tb;
	import lmsd_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CALM_ITEMS   = 300;   // tail of the run without idling
	localparam int HOLD_AFTER   = 300;   // results seen before the long hold-off
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 12;
	// stuck limit well above the clearing pass, the hold-off and the longest stall burst
	localparam int STUCK_LIMIT  = 4000;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		logic [SEC_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             up;
		logic             low;
		logic             latch;
	} scan_word_t;

	// Predicts scan words from accepted input words and checks the output stream.
	class scan_scoreboard;
		pix_byte_t        frame [STORE_BYTES];
		logic [SEC_W-1:0] section;
		logic [COL_W-1:0] column;
		scan_word_t       pending [$];
		int unsigned      mismatches;
		int unsigned      results;

		function new();
			foreach (frame[i]) frame[i] = '0;
			section    = '0;
			column     = '0;
			mismatches = 0;
			results    = 0;
		endfunction

		// byte holding the upper or lower pixel of a column in a section
		function logic [ADDR_W-1:0] pixel_address(logic [SEC_W-1:0] sec, logic [COL_W-1:0] col,
				bit lower);
			int base;
			if (sec < SEC_W'(8))
				base = col[COL_W-1] ? (lower ? 640 : 384) : (lower ? 256 : 0);
			else
				base = col[COL_W-1] ? (lower ? 768 : 512) : (lower ? 384 : 128);
			return ADDR_W'(base) + ADDR_W'(col);
		endfunction

		function void note_word(req_type_t kind, logic [ADDR_W-1:0] addr, pix_byte_t val);
			scan_word_t w;
			logic [2:0] bitpos;
			if (kind == REQ_WRITE) begin
				frame[addr] = val;
				return;
			end
			bitpos  = section[2:0];
			w.row   = section;
			w.col   = column;
			w.up    = frame[pixel_address(section, column, 1'b0)][bitpos];
			w.low   = frame[pixel_address(section, column, 1'b1)][bitpos];
			w.latch = (column == LAST_COLUMN);
			pending.push_back(w);
			if (w.latch) begin
				column  = '0;
				section = section + 1'b1;   // wraps at 16
			end else begin
				column = column + 1'b1;
			end
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("scan word %0d: %s expected %0h, got %0h", results, field, want, got);
		endfunction

		function void check_word(logic [15:0] data, logic last);
			scan_word_t w;
			results++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("scan word %0d: not expected, data %0h last %0b",
						results, data, last);
				return;
			end
			w = pending.pop_front();
			if (data[3:0] !== w.row)  report("row_select", w.row, data[3:0]);
			if (data[11:4] !== w.col) report("column_index", w.col, data[11:4]);
			if (data[12] !== w.up)    report("upper_on", w.up, data[12]);
			if (data[13] !== w.low)   report("lower_on", w.low, data[13]);
			if (last !== w.latch)     report("latch_row", w.latch, last);
			if (data[15:14] !== 2'b00) report("padding", 0, data[15:14]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [9:0] byte_address, [17:10] byte_value, rest zero
	logic        s_tuser;   // [0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [3:0] row_select, [11:4] column_index, [12] upper_on,
	                        // [13] lower_on, rest zero
	logic        m_tlast;   // latch_row

	scan_scoreboard sb;
	bit          calm;       // no idling on either side
	bit          holding;    // long receiver hold-off in progress
	bit          hold_done;
	int unsigned stuck;

	led_matrix_scan_driver_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Drive one word from a falling edge, hold it until taken, return at the next falling edge.
	task automatic send_word(req_type_t kind, logic [ADDR_W-1:0] addr, pix_byte_t val);
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = {6'b0, val, addr};
		do @(posedge clk); while (!s_tready);
		sb.note_word(kind, addr, val);
		@(negedge clk);
	endtask

	task automatic idle_gap(int unsigned n);
		s_tvalid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Receiver: random stall bursts, one long hold-off so the block backs up its input.
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && !hold_done && sb.results >= HOLD_AFTER) begin
				m_tready = 1'b0;
				holding  = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				holding   = 1'b0;
				hold_done = 1'b1;
				m_tready  = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Output monitor: every taken result goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tlast);
	end

	// Watchdog: counts cycles with no handshake on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck <= 0;
		end else if (stuck + 1 >= STUCK_LIMIT) begin
			$display("led_matrix_scan_driver_unit_tb: FAIL");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	initial begin
		int unsigned items;
		bit          idle_on;
		logic [COL_W-1:0] col_ahead;
		logic [ADDR_W-1:0] addr;
		pix_byte_t   val;

		sb        = new();
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_WRITE;
		m_tready  = 1'b0;
		calm      = 1'b0;
		holding   = 1'b0;
		hold_done = 1'b0;
		stuck     = 0;
		items     = 0;
		idle_on   = 1'b1;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed: store extremes, write then immediate read, first columns of section 0.
		// s_tready stays low through the clearing pass; send_word just waits it out.
		send_word(REQ_WRITE, 10'd0, 8'hFF);
		send_word(REQ_WRITE, 10'd256, 8'h01);
		send_word(REQ_WRITE, 10'd1, 8'hFE);
		send_word(REQ_WRITE, 10'd257, 8'h80);
		send_word(REQ_TICK, 10'd0, 8'h00);      // col 0: both on
		send_word(REQ_TICK, 10'd0, 8'h00);      // col 1: both off (bit 0 clear)
		send_word(REQ_WRITE, 10'd1023, 8'hFF);
		send_word(REQ_WRITE, 10'd512, 8'hAA);
		send_word(REQ_WRITE, 10'd2, 8'h55);
		send_word(REQ_TICK, 10'd0, 8'h00);      // col 2: upper only
		send_word(REQ_WRITE, 10'd259, 8'hFF);   // lower of col 3, read by the next tick
		send_word(REQ_TICK, 10'h3FF, 8'hFF);    // tick ignores address and value
		send_word(REQ_WRITE, 10'd0, 8'h00);
		send_word(REQ_WRITE, 10'd767, 8'h55);
		send_word(REQ_WRITE, 10'd4, 8'h01);
		send_word(REQ_TICK, 10'd0, 8'h00);      // col 4: upper from the write just before
		send_word(REQ_WRITE, 10'h2AA, 8'h7F);
		send_word(REQ_WRITE, 10'h155, 8'h80);
		send_word(REQ_TICK, 10'd0, 8'h00);

		// Random: mostly ticks, writes mostly aimed at bytes the next few ticks read.
		while (items < RANDOM_ITEMS) begin
			if (items % 64 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			calm = (items + CALM_ITEMS >= RANDOM_ITEMS);
			if (idle_on && !calm && !holding && $urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 18));
			if ($urandom_range(0, 9) < 8) begin
				send_word(REQ_TICK, ADDR_W'($urandom), 8'($urandom));
			end else begin
				if ($urandom_range(0, 9) < 6) begin
					col_ahead = sb.column + COL_W'($urandom_range(0, 7));
					addr = sb.pixel_address(sb.section, col_ahead, 1'($urandom_range(0, 1)));
				end else begin
					addr = ADDR_W'($urandom);
				end
				case ($urandom_range(0, 5))
					0:       val = 8'h00;
					1:       val = 8'hFF;
					default: val = 8'($urandom);
				endcase
				send_word(REQ_WRITE, addr, val);
			end
			items++;
		end
		s_tvalid = 1'b0;

		// wait for every expected scan word, then keep watching for strays
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("led_matrix_scan_driver_unit_tb: PASS");
		else
			$display("led_matrix_scan_driver_unit_tb: FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/lmsd_pkg.sv
rtl/lmsd_ram.sv
rtl/led_matrix_scan_driver_unit.sv
tb/sv/led_matrix_scan_driver_unit_tb.sv
